[design/pulse_brightness_tracker_top_defines.svh]
// Assertion macros shared by the pulse brightness tracker checker.
`ifndef PULSE_BRIGHTNESS_TRACKER_TOP_DEFINES_SVH
`define PULSE_BRIGHTNESS_TRACKER_TOP_DEFINES_SVH

// Checks a property on every clock edge once reset has been released.
`define PBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset cycles included.
`define PBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pbt_pkg.sv]
// Shared constants and types of the pulse brightness tracker.
package pbt_pkg;

  localparam int BLOCK_LEN     = 100;
  localparam int WINDOW_BLOCKS = 4;
  localparam int SAMPLE_BITS   = 18;
  localparam int LEVEL_W       = 8;
  localparam int POS_W         = $clog2(BLOCK_LEN);
  localparam int SLOT_W        = (WINDOW_BLOCKS > 1) ? $clog2(WINDOW_BLOCKS) : 1;
  // Scaled difference diff * MAX_LEVEL.
  localparam int NUM_W         = SAMPLE_BITS + LEVEL_W;
  // One quotient bit above the level range flags saturation.
  localparam int QUO_W         = LEVEL_W + 1;
  localparam int STEP_W        = $clog2(QUO_W);

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 8'd255;

  // One classified sample handed from the front end to the back end.
  typedef struct packed {
    logic                   zero;
    logic                   rise;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] range;
  } pbt_job_t;

endpackage

[design/pbt_front.sv]
// Front end: window tracking and classification of each red sample.
module pbt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic [pbt_pkg::SAMPLE_BITS-1:0] in_red_sample,
  input  logic                           q_full,
  output logic                           q_push,
  output pbt_pkg::pbt_job_t              q_job
);
  import pbt_pkg::*;

  logic [SAMPLE_BITS-1:0] blk_min_r [WINDOW_BLOCKS];
  logic [SAMPLE_BITS-1:0] blk_max_r [WINDOW_BLOCKS];
  logic [SAMPLE_BITS-1:0] run_min_r, run_max_r;
  logic [SAMPLE_BITS-1:0] win_min_r, win_max_r;
  logic [SAMPLE_BITS-1:0] prev_r;
  logic [POS_W-1:0]       pos_r;
  logic [SLOT_W-1:0]      slot_r;

  logic [SAMPLE_BITS-1:0] store_lo, store_hi, lo, hi, rng;
  logic [SAMPLE_BITS-1:0] run_min_upd, run_max_upd;
  logic                   accept, rise, block_end;

  assign accept = in_push && !q_full;
  assign q_push = accept;

  always_comb begin
    store_lo = blk_min_r[0];
    store_hi = blk_max_r[0];
    for (int k = 1; k < WINDOW_BLOCKS; k++) begin
      if (blk_min_r[k] < store_lo) store_lo = blk_min_r[k];
      if (blk_max_r[k] > store_hi) store_hi = blk_max_r[k];
    end
  end

  // The window is refreshed from the block stores at the first sample of a block.
  assign lo   = (pos_r == '0) ? store_lo : win_min_r;
  assign hi   = (pos_r == '0) ? store_hi : win_max_r;
  assign rng  = (hi > lo) ? (hi - lo) : '0;
  assign rise = in_red_sample > prev_r;

  assign q_job.zero  = (rng == '0);
  assign q_job.rise  = rise;
  assign q_job.diff  = rise ? (in_red_sample - prev_r) : (prev_r - in_red_sample);
  assign q_job.range = rng;

  assign run_min_upd = (in_red_sample < run_min_r) ? in_red_sample : run_min_r;
  assign run_max_upd = (in_red_sample > run_max_r) ? in_red_sample : run_max_r;
  assign block_end   = (pos_r == POS_W'(BLOCK_LEN - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW_BLOCKS; k++) begin
        blk_min_r[k] <= '0;
        blk_max_r[k] <= '0;
      end
      run_min_r <= '1;
      run_max_r <= '0;
      win_min_r <= '0;
      win_max_r <= '0;
      prev_r    <= '0;
      pos_r     <= '0;
      slot_r    <= '0;
    end else if (accept) begin
      win_min_r <= lo;
      win_max_r <= hi;
      prev_r    <= in_red_sample;
      if (block_end) begin
        blk_min_r[slot_r] <= run_min_upd;
        blk_max_r[slot_r] <= run_max_upd;
        slot_r    <= (slot_r == SLOT_W'(WINDOW_BLOCKS - 1)) ? '0 : slot_r + 1'b1;
        run_min_r <= '1;
        run_max_r <= '0;
        pos_r     <= '0;
      end else begin
        run_min_r <= run_min_upd;
        run_max_r <= run_max_upd;
        pos_r     <= pos_r + 1'b1;
      end
    end
  end

endmodule

[design/pbt_queue.sv]
// Two-entry queue that decouples the front end from the back end.
module pbt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pbt_pkg::pbt_job_t push_job,
  input  logic              pop,
  output pbt_pkg::pbt_job_t head_job,
  output logic              full,
  output logic              empty
);
  import pbt_pkg::*;

  pbt_job_t   ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head_job = ent_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

[design/pbt_back.sv]
// Back end: shift-subtract scaling of the difference and level update.
module pbt_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  pbt_pkg::pbt_job_t           q_head,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [pbt_pkg::LEVEL_W-1:0] out_brightness,
  output logic                        out_range_zero
);
  import pbt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

  state_t             state_r, state_nxt;
  logic [NUM_W-1:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0]   div_r, div_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               rise_r, rise_nxt;
  logic               zero_r, zero_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_bright_r, out_bright_nxt;
  logic               out_zero_r, out_zero_nxt;

  logic               ge, slot_free;
  logic [LEVEL_W-1:0] headroom, new_level;

  assign ge        = (rem_r >= div_r);
  assign slot_free = !out_valid_r || out_pop;
  assign headroom  = MAX_LEVEL - level_r;

  // A quotient of 256 or more saturates in either direction.
  always_comb begin
    if (zero_r) begin
      new_level = level_r;
    end else if (rise_r) begin
      new_level = (quo_r >= {1'b0, level_r}) ? '0 : level_r - quo_r[LEVEL_W-1:0];
    end else begin
      new_level = (quo_r >= {1'b0, headroom}) ? MAX_LEVEL
                                              : level_r + quo_r[LEVEL_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    rise_nxt       = rise_r;
    zero_nxt       = zero_r;
    level_nxt      = level_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    out_bright_nxt = out_bright_r;
    out_zero_nxt   = out_zero_r;
    q_pop          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          zero_nxt  = q_head.zero;
          rise_nxt  = q_head.rise;
          rem_nxt   = NUM_W'(q_head.diff) * NUM_W'(MAX_LEVEL);
          div_nxt   = {q_head.range, {LEVEL_W{1'b0}}};
          quo_nxt   = '0;
          step_nxt  = STEP_W'(QUO_W - 1);
          state_nxt = q_head.zero ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? rem_r - div_r : rem_r;
        quo_nxt  = {quo_r[QUO_W-2:0], ge};
        div_nxt  = div_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          level_nxt      = new_level;
          out_bright_nxt = new_level;
          out_zero_nxt   = zero_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    rise_r       <= rise_nxt;
    zero_r       <= zero_nxt;
    out_bright_r <= out_bright_nxt;
    out_zero_r   <= out_zero_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_brightness = out_bright_r;
  assign out_range_zero = out_zero_r;

endmodule

[design/pulse_brightness_tracker_top.sv]
// Pulse brightness tracker: red optical samples in, indicator brightness out.
//
// Input channel: drive in_red_sample with in_push high; the sample transfers
// at a clock edge where in_push is high and in_full is low.
// Result channel: while out_empty is low, out_brightness and out_range_zero
// hold the oldest result; it transfers at an edge where out_pop is high.
// Every sample gives exactly one result, in order.
// The back end handles one sample at a time: a pick-up step that pops the
// queue, nine shift-subtract steps of the scaling divider, and an update step
// that writes the result once the result register is free. A zero window
// range skips the divider. The divider sets the rate.
// The front end takes a sample per cycle while the two-entry queue has room, so
// in_full rises only when that queue is full.
// Reset (rst_n low at a clock edge) clears the block stores, the window, the
// level, the queue and the result register; results in flight are dropped.
// When the receiver stalls, the held result stays on the ports, the back end
// waits with the next result, and in_full rises once the queue fills.
module pulse_brightness_tracker_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [pbt_pkg::SAMPLE_BITS-1:0] in_red_sample,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [pbt_pkg::LEVEL_W-1:0]     out_brightness,
  output logic                            out_range_zero
);
  import pbt_pkg::*;

  pbt_job_t push_job, head_job;
  logic     q_push, q_pop, q_full, q_empty;

  assign in_full = q_full;

  pbt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_red_sample(in_red_sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  pbt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .head_job(head_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  pbt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (head_job),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_brightness(out_brightness),
    .out_range_zero(out_range_zero)
  );

endmodule

[design/pbt_checker.sv]
// Port-level checker for the pulse brightness tracker, bound to the top level.
`include "pulse_brightness_tracker_top_defines.svh"

module pbt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_full,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic [pbt_pkg::LEVEL_W-1:0] out_brightness,
  input logic                        out_range_zero
);
  import pbt_pkg::*;

  // Brightness of the last result that transferred; a held level repeats it.
  logic [LEVEL_W-1:0] last_bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_bright_r <= '0;
    end else if (out_pop && !out_empty) begin
      last_bright_r <= out_brightness;
    end
  end

  `PBT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> out_empty, "result after reset")
  `PBT_ASSERT_ALWAYS(a_reset_not_full, !rst_n |=> !in_full, "input full after reset")
  `PBT_ASSERT(a_result_held, !out_empty && !out_pop |=> !out_empty && $stable(out_brightness) && $stable(out_range_zero), "stalled result changed")
  `PBT_ASSERT(a_zero_range_holds, !out_empty && out_range_zero |-> out_brightness == last_bright_r, "level moved on a zero range")

endmodule

bind pulse_brightness_tracker_top pbt_checker u_pbt_checker (.*);

[test/tb_pulse_brightness_tracker_top.sv]
// Self-checking testbench for the pulse brightness tracker with its own brightness predictor.
module tb_pulse_brightness_tracker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pbt_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int TOTAL_SAMPLES = 1700;
  localparam int FLAT_RUN      = 500;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP = '1;

  typedef struct {
    logic [LEVEL_W-1:0] brightness;
    logic               range_zero;
  } pulse_result_t;

  // Tracks the window and level exactly as the block should, and holds the
  // brightness values that are still owed by the block.
  class brightness_board;
    logic [SAMPLE_BITS-1:0] blk_min [WINDOW_BLOCKS];
    logic [SAMPLE_BITS-1:0] blk_max [WINDOW_BLOCKS];
    logic [SAMPLE_BITS-1:0] run_min, run_max, win_min, win_max, prev;
    logic [LEVEL_W-1:0]     lvl;
    int                     pos, slot;
    pulse_result_t          owed_levels[$];
    int unsigned            errors, checked, held, floor_hits, ceiling_hits;

    function new();
      for (int k = 0; k < WINDOW_BLOCKS; k++) begin
        blk_min[k] = '0;
        blk_max[k] = '0;
      end
      run_min = '1;
      run_max = '0;
      win_min = '0;
      win_max = '0;
      prev    = '0;
      lvl     = '0;
      pos     = 0;
      slot    = 0;
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] s);
      logic [SAMPLE_BITS-1:0] span, diff;
      logic [NUM_W-1:0]       amount, headroom;
      logic                   rise;
      pulse_result_t          r;
      if (pos == 0) begin
        win_min = blk_min[0];
        win_max = blk_max[0];
        for (int k = 1; k < WINDOW_BLOCKS; k++) begin
          if (blk_min[k] < win_min) win_min = blk_min[k];
          if (blk_max[k] > win_max) win_max = blk_max[k];
        end
      end
      span = (win_max > win_min) ? win_max - win_min : '0;
      if (span != '0) begin
        rise     = s > prev;
        diff     = rise ? s - prev : prev - s;
        amount   = (NUM_W'(diff) * NUM_W'(MAX_LEVEL)) / NUM_W'(span);
        headroom = NUM_W'(MAX_LEVEL) - NUM_W'(lvl);
        if (rise) begin
          lvl = (amount >= NUM_W'(lvl)) ? '0 : lvl - LEVEL_W'(amount);
        end else begin
          lvl = (amount >= headroom) ? MAX_LEVEL : lvl + LEVEL_W'(amount);
        end
        if (lvl == '0) floor_hits++;
        if (lvl == MAX_LEVEL) ceiling_hits++;
      end else begin
        held++;
      end
      prev = s;
      if (s < run_min) run_min = s;
      if (s > run_max) run_max = s;
      pos++;
      if (pos >= BLOCK_LEN) begin
        blk_min[slot] = run_min;
        blk_max[slot] = run_max;
        slot    = (slot + 1) % WINDOW_BLOCKS;
        run_min = '1;
        run_max = '0;
        pos     = 0;
      end
      r.brightness = lvl;
      r.range_zero = (span == '0);
      owed_levels.push_back(r);
    endfunction

    function void check_result(logic [LEVEL_W-1:0] b, logic z);
      pulse_result_t want;
      if (owed_levels.size() == 0) begin
        $error("result with nothing expected: brightness %0d, range_zero %0d", b, z);
        errors++;
        return;
      end
      want = owed_levels.pop_front();
      checked++;
      if (b !== want.brightness) begin
        $error("brightness mismatch: expected %0d, actual %0d", want.brightness, b);
        errors++;
      end
      if (z !== want.range_zero) begin
        $error("range_zero mismatch: expected %0d, actual %0d", want.range_zero, z);
        errors++;
      end
    endfunction

    function int pending();
      return owed_levels.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_push = 1'b0;
  logic                   in_full;
  logic [SAMPLE_BITS-1:0] in_red_sample = '0;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  logic [LEVEL_W-1:0]     out_brightness;
  logic                   out_range_zero;

  brightness_board board;
  int              sent;
  int              send_gap_max;
  int              idle_cycles;

  pulse_brightness_tracker_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_red_sample  (in_red_sample),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_brightness (out_brightness),
    .out_range_zero (out_range_zero)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic push_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push       <= 1'b1;
    in_red_sample <= s;
    do @(posedge clk); while (in_full);
    board.note_sample(s);
    sent++;
  endtask

  // Holds the sender off until every owed result has been transferred.
  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic run_segment();
    int     kind, len, amp, period, phase, lo, hi, dwell;
    longint base, val;
    kind         = $urandom_range(0, 9);
    send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
    if (kind <= 4) begin
      // Pulse-like triangle wave with ripple and an occasional wild spike.
      len    = $urandom_range(80, 300);
      case ($urandom_range(0, 2))
        0:       amp = $urandom_range(1, 40);
        1:       amp = $urandom_range(40, 4000);
        default: amp = $urandom_range(4000, 200000);
      endcase
      period = $urandom_range(8, 80);
      base   = $urandom_range(0, SAMPLE_TOP - amp - amp / 8);
      for (int i = 0; i < len; i++) begin
        phase = i % period;
        val   = base + longint'(phase < period / 2 ? phase : period - phase) * 2 * amp / period
                + $urandom_range(0, amp / 8);
        if ($urandom_range(0, 59) == 0) val = $urandom_range(0, SAMPLE_TOP);
        push_sample(SAMPLE_BITS'(val));
      end
    end else if (kind == 5) begin
      len = $urandom_range(10, 80);
      for (int i = 0; i < len; i++) push_sample(SAMPLE_BITS'($urandom));
    end else if (kind <= 7) begin
      len = $urandom_range(20, 150);
      case ($urandom_range(0, 3))
        0:       val = 0;
        1:       val = SAMPLE_TOP;
        default: val = $urandom_range(0, SAMPLE_TOP);
      endcase
      for (int i = 0; i < len; i++) push_sample(SAMPLE_BITS'(val));
    end else begin
      len   = $urandom_range(40, 160);
      lo    = $urandom_range(0, SAMPLE_TOP);
      hi    = $urandom_range(lo, SAMPLE_TOP);
      dwell = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) push_sample(SAMPLE_BITS'(((i / dwell) % 2) ? hi : lo));
    end
  endtask

  initial begin
    logic [SAMPLE_BITS-1:0] opening [$];
    logic [SAMPLE_BITS-1:0] flat_value;
    opening = '{18'h00000, 18'h3FFFF, 18'h00000, 18'h00001, 18'h3FFFE, 18'h3FFFF,
                18'h3FFFF, 18'h2AAAA, 18'h15555, 18'h00000, 18'h00000, 18'h20000,
                18'h1FFFF, 18'h3FFFF, 18'h00001, 18'h0F0F0, 18'h30F0F, 18'h00000};
    board        = new();
    sent         = 0;
    send_gap_max = 14;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The first window has no history, so these all hold the level at zero.
    foreach (opening[i]) push_sample(opening[i]);
    drain_results();

    while (sent < TOTAL_SAMPLES / 2) run_segment();

    // A long flat stretch fills the whole window, so the range collapses to
    // zero with a level that is usually not zero.
    drain_results();
    send_gap_max = 14;
    flat_value   = ($urandom_range(0, 1) == 0) ? SAMPLE_TOP : SAMPLE_BITS'($urandom);
    for (int i = 0; i < FLAT_RUN; i++) push_sample(flat_value);

    while (sent < TOTAL_SAMPLES) run_segment();

    @(negedge clk);
    in_push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d samples and checked %0d results, %0d of them with a zero window range.",
             sent, board.checked, board.held);
    $display("Brightness hit the floor %0d times and the ceiling %0d times.",
             board.floor_hits, board.ceiling_hits);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: pops with random stalls, in runs that switch stalling on and off.
  initial begin
    int stall, stall_max, run_left;
    stall_max = 14;
    run_left  = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (run_left == 0) begin
        run_left  = $urandom_range(30, 200);
        stall_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      end
      run_left--;
      stall = $urandom_range(0, stall_max);
      repeat (stall) begin
        @(negedge clk);
        out_pop <= 1'b0;
      end
      @(negedge clk);
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      board.check_result(out_brightness, out_range_zero);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Timed out after %0d cycles without a transfer.", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
